@@ src/bms_pkg.sv @@
package bms_pkg;

  localparam int unsigned DATA_W = 32;

  // read port address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,     // entry below the fill count
    RD_NEXT,    // entry two below the current hole
    RD_MEDIAN   // entry at fill count / 2
  } rd_sel_t;

  // write port source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_VAL_POS,  // new sample into the hole
    WR_SHIFT,    // move larger entry up into the hole
    WR_VAL_ZERO  // new sample at the bottom
  } wr_sel_t;

  typedef struct packed {
    logic    take;
    logic    mark_ovf;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    pos_load;
    logic    pos_dec;
    logic    count_inc;
    logic    finish;
  } bms_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
    logic greater;
    logic pos_one;
    logic out_free;
  } bms_status_t;

endpackage

@@ src/bms_ram.sv @@
module bms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bms_datapath.sv @@
module bms_datapath #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bms_pkg::bms_cmd_t              cmd,
  output bms_pkg::bms_status_t           status,
  input  logic signed [bms_pkg::DATA_W-1:0] sample,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [bms_pkg::DATA_W-1:0] median,
  output logic                           overflowed
);

  import bms_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic signed [DATA_W-1:0] value;
  logic                     last_flag;
  logic [CW-1:0]            count;
  logic                     ovf;
  logic [AW-1:0]            pos;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_half;

  assign count_m1   = count - CW'(1);
  assign count_half = count >> 1;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = value;
    case (cmd.wr)
      WR_VAL_POS: begin
        we = 1'b1;
      end
      WR_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
      end
      WR_VAL_ZERO: begin
        we    = 1'b1;
        waddr = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    re    = 1'b1;
    raddr = '0;
    case (cmd.rd)
      RD_TOP:    raddr = count_m1[AW-1:0];
      RD_NEXT:   raddr = pos - AW'(2);
      RD_MEDIAN: raddr = count_half[AW-1:0];
      default:   re = 1'b0;
    endcase
  end

  bms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value     <= sample;
      last_flag <= last;
    end
    if (cmd.pos_load) begin
      pos <= count[AW-1:0];
    end else if (cmd.pos_dec) begin
      pos <= pos - AW'(1);
    end
    if (cmd.finish) begin
      median     <= $signed(rdata);
      overflowed <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        if (cmd.count_inc) begin
          count <= count + CW'(1);
        end
        if (cmd.mark_ovf) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.full     = (count == CW'(MAX_SAMPLES));
  assign status.empty    = (count == '0);
  assign status.last     = last_flag;
  assign status.greater  = ($signed(rdata) > value);
  assign status.pos_one  = (pos == AW'(1));
  assign status.out_free = !out_valid || !out_stall;

endmodule

@@ src/bms_ctrl.sv @@
module bms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bms_pkg::bms_status_t status,
  output bms_pkg::bms_cmd_t    cmd
);

  import bms_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DECIDE,
    SHIFT,
    PLACE,
    MED_RD,
    MED_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd     = RD_NONE;
    cmd.wr     = WR_NONE;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        if (status.full) begin
          cmd.mark_ovf = 1'b1;
          state_next   = status.last ? MED_RD : IDLE;
        end else if (status.empty) begin
          cmd.wr        = WR_VAL_ZERO;
          cmd.count_inc = 1'b1;
          state_next    = status.last ? MED_RD : IDLE;
        end else begin
          cmd.rd       = RD_TOP;
          cmd.pos_load = 1'b1;
          state_next   = SHIFT;
        end
      end
      SHIFT: begin
        // read data is the entry just below the hole
        if (status.greater) begin
          cmd.wr      = WR_SHIFT;
          cmd.pos_dec = 1'b1;
          if (status.pos_one) begin
            state_next = PLACE;
          end else begin
            cmd.rd = RD_NEXT;
          end
        end else begin
          cmd.wr        = WR_VAL_POS;
          cmd.count_inc = 1'b1;
          state_next    = status.last ? MED_RD : IDLE;
        end
      end
      PLACE: begin
        cmd.wr        = WR_VAL_ZERO;
        cmd.count_inc = 1'b1;
        state_next    = status.last ? MED_RD : IDLE;
      end
      MED_RD: begin
        cmd.rd     = RD_MEDIAN;
        state_next = MED_WAIT;
      end
      MED_WAIT: begin
        // read data holds until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

@@ src/block_median_select.sv @@
// Median of a set of signed Q16.16 samples.
// Input channel: sample and last with in_valid / in_stall; a transfer happens
// on a clock edge with in_valid high and in_stall low. last marks the final
// sample of a set. Output channel: median and overflowed with out_valid /
// out_stall, one result per set, given after its final sample.
// Samples are held in ascending order in a single-port-write RAM; each one
// is inserted by walking down from the top, one entry moved per cycle.
// After each transfer in_stall stays high while the sample is inserted:
// DECIDE, then one SHIFT step per larger held entry and a final SHIFT or
// PLACE write (DECIDE alone when the set is empty or the store is full). On
// a final sample the median read (MED_RD, MED_WAIT) follows before out_valid
// rises; MED_WAIT holds while the output register is occupied and stalled.
// The result is the entry at sorted index count/2 (upper median for even
// counts). Samples beyond MAX_SAMPLES are dropped and flagged in overflowed.
// The result sits in an output register: a stalled receiver does not block
// the next set's samples, only the next result's load.
// Reset (rst, synchronous) empties the set and drops any pending result;
// no clearing pass is needed.
module block_median_select #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [bms_pkg::DATA_W-1:0] sample,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bms_pkg::DATA_W-1:0] median,
  output logic                              overflowed
);

  import bms_pkg::*;

  bms_cmd_t    cmd;
  bms_status_t status;

  bms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bms_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (sample),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .median     (median),
    .overflowed (overflowed)
  );

endmodule

@@ src/bms_checker.sv @@
module bms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] median,
  input logic        overflowed
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // and unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(median) && $stable(overflowed))
    else $error("stalled result changed");

  // every sample transfer is followed by in_stall high
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sample taken on consecutive cycles");

  // reset drops any pending result
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind block_median_select bms_checker u_bms_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .median     (median),
  .overflowed (overflowed)
);
